// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the shader RTL.
// No dependencies; included by modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled during reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Plain invariant on every clock edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  `ASSERT_CLK(lbl, (expr), msg)

`endif

// ----- rtl/core/ttps_pkg.sv -----
// Package for the textured triangle pixel shader: widths, register
// indexes, pipeline types and the divider step. No dependencies.
`timescale 1ns / 1ps

package ttps_pkg;

  localparam int DEF_TEX_WIDTH     = 256;
  localparam int DEF_TEX_HEIGHT    = 256;
  localparam int DEF_SCREEN_WIDTH  = 1024;
  localparam int DEF_SCREEN_HEIGHT = 1024;

  localparam int COORD_W = 12;
  localparam int TEXC_W  = 10;
  localparam int RGB_W   = 24;
  localparam int DIFF_W  = 13;
  localparam int PROD_W  = 26;
  localparam int CROSS_W = 27;
  localparam int SUM_W   = 29;
  localparam int WT_W    = 26;
  localparam int NUM_W   = 36;
  localparam int FRAC_W  = 8;
  localparam int QUOT_W  = TEXC_W + FRAC_W;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_VERT_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERT_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_SEL = 3'd4;

  localparam logic OP_SHADE = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  typedef struct packed {
    logic              vld;
    logic              load;
    logic              hit;
    logic [TEXC_W-1:0] lx;
    logic [TEXC_W-1:0] ly;
    logic [RGB_W-1:0]  rgb;
  } item_ctl_t;

  typedef struct packed {
    logic [TEXC_W-1:0] ax;
    logic [TEXC_W-1:0] ay;
    logic [TEXC_W-1:0] bx;
    logic [TEXC_W-1:0] by;
  } tex_pts_t;

  typedef struct packed {
    logic [WT_W-1:0]   rem;
    logic [QUOT_W-1:0] quo;
  } div_t;

  // One restoring step: shift in the next numerator bit, subtract if it fits.
  function automatic div_t div_step(div_t s, logic [WT_W-1:0] den);
    logic [WT_W:0] t;
    logic          q;
    div_t          r;
    t = {s.rem, s.quo[QUOT_W-1]};
    q = (t >= {1'b0, den});
    if (q) begin
      t = t - {1'b0, den};
    end
    r.rem = t[WT_W-1:0];
    r.quo = {s.quo[QUOT_W-2:0], q};
    return r;
  endfunction

endpackage

// ----- rtl/core/textured_triangle_pixel_shader.sv -----
// Channel   Dir  tdata / tuser                                  Item
// s_axis    in   tdata 136b vertices, tex points, pixel, rgb    one op
//                tuser operation
// m_axis    out  tdata red, green, blue; tuser covered         one result
// cfg       in   cfg_we / cfg_index / cfg_data                 register write
//
// One item per cycle while the output is not stalled; most of the pipe is the 18-stage divider.
// Texels sit in four parity banks so the four bilinear taps read at once.
// Reset clears control only; texture banks are undefined until loaded.
// Output stalls freeze the pipe; a one-item skid takes the item offered in the
// first stalled cycle, then s_axis_tready stays low until the skid drains.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module textured_triangle_pixel_shader
  import ttps_pkg::*;
#(
  parameter int TEX_WIDTH     = DEF_TEX_WIDTH,
  parameter int TEX_HEIGHT    = DEF_TEX_HEIGHT,
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // vert_a_x, vert_a_y, vert_b_x, vert_b_y, tex_a_x, tex_a_y, tex_b_x,
  // tex_b_y, pixel_x, pixel_y, texel_rgb
  input  logic [135:0]         s_axis_tdata,
  // operation
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // red, green, blue
  output logic [23:0]          m_axis_tdata,
  // covered
  output logic                 m_axis_tuser,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  localparam int BANK_W     = (TEX_WIDTH + 1) / 2;
  localparam int BANK_H     = (TEX_HEIGHT + 1) / 2;
  localparam int BANK_TEX   = BANK_W * BANK_H;
  localparam int BANK_DEPTH = 2 * BANK_TEX;
  localparam int ADDR_W     = $clog2(BANK_DEPTH);
  localparam logic [12:0] SCR_W = 13'(SCREEN_WIDTH);
  localparam logic [12:0] SCR_H = 13'(SCREEN_HEIGHT);
  localparam logic [12:0] TW13  = 13'(TEX_WIDTH);
  localparam logic [12:0] TH13  = 13'(TEX_HEIGHT);
  localparam logic [10:0] TW11  = 11'(TEX_WIDTH);
  localparam logic [10:0] TH11  = 11'(TEX_HEIGHT);

  // configuration
  logic signed [COORD_W-1:0] cvx, cvy;
  logic [TEXC_W-1:0]         ctx, cty;
  logic                      tsel;

  always_ff @(posedge clk) begin
    if (rst) begin
      cvx <= '0;
      cvy <= '0;
      ctx <= '0;
      cty <= '0;
      tsel <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VERT_X:  cvx <= cfg_data;
        CFG_VERT_Y:  cvy <= cfg_data;
        CFG_TEX_X:   ctx <= cfg_data[TEXC_W-1:0];
        CFG_TEX_Y:   cty <= cfg_data[TEXC_W-1:0];
        CFG_TEX_SEL: tsel <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input skid
  logic         advance;
  logic         skid_full;
  logic [135:0] skid_data;
  logic         skid_op;
  logic         in_take;
  logic         in_vld;
  logic [135:0] in_data;
  logic         in_op;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !skid_full;
  assign in_take       = s_axis_tvalid && !skid_full;
  assign in_vld        = skid_full || in_take;
  assign in_data       = skid_full ? skid_data : s_axis_tdata;
  assign in_op         = skid_full ? skid_op : s_axis_tuser;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (in_take && !advance) begin
      skid_full <= 1'b1;
    end else if (advance) begin
      skid_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && !advance) begin
      skid_data <= s_axis_tdata;
      skid_op   <= s_axis_tuser;
    end
  end

  // field split
  logic signed [COORD_W-1:0] ax, ay, bx, by, px, py;
  tex_pts_t                  in_tex;
  logic [RGB_W-1:0]          in_rgb;

  assign ax        = in_data[11:0];
  assign ay        = in_data[23:12];
  assign bx        = in_data[35:24];
  assign by        = in_data[47:36];
  assign in_tex.ax = in_data[57:48];
  assign in_tex.ay = in_data[67:58];
  assign in_tex.bx = in_data[77:68];
  assign in_tex.by = in_data[87:78];
  assign px        = in_data[99:88];
  assign py        = in_data[111:100];
  assign in_rgb    = in_data[135:112];

  // stage 1: differences, screen and texture range
  logic signed [DIFF_W-1:0] bax1, cay1, cax1, bay1, pax1, pay1;
  tex_pts_t                 tex1;
  item_ctl_t                ctl1, ctl1_next;
  logic                     on_scr, in_tex_rng;

  always_comb begin
    on_scr = !px[11] && !py[11] && ({2'b0, px[10:0]} < SCR_W)
             && ({2'b0, py[10:0]} < SCR_H);
    in_tex_rng = !px[11] && !py[11] && ({2'b0, px[10:0]} < TW13)
                 && ({2'b0, py[10:0]} < TH13);
    ctl1_next.vld  = in_vld;
    ctl1_next.load = (in_op == OP_LOAD);
    ctl1_next.hit  = (in_op == OP_LOAD) ? in_tex_rng : on_scr;
    ctl1_next.lx   = px[TEXC_W-1:0];
    ctl1_next.ly   = py[TEXC_W-1:0];
    ctl1_next.rgb  = in_rgb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else if (advance) begin
      ctl1 <= ctl1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      bax1 <= {bx[11], bx} - {ax[11], ax};
      cay1 <= {cvy[11], cvy} - {ay[11], ay};
      cax1 <= {cvx[11], cvx} - {ax[11], ax};
      bay1 <= {by[11], by} - {ay[11], ay};
      pax1 <= {px[11], px} - {ax[11], ax};
      pay1 <= {py[11], py} - {ay[11], ay};
      tex1 <= in_tex;
    end
  end

  // stage 2: cross products
  logic signed [PROD_W-1:0] p1, p2, p3, p4, p5, p6;
  tex_pts_t                 tex2;
  item_ctl_t                ctl2;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2 <= '0;
    end else if (advance) begin
      ctl2 <= ctl1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p1 <= bax1 * cay1;
      p2 <= cax1 * bay1;
      p3 <= pax1 * cay1;
      p4 <= cax1 * pay1;
      p5 <= bax1 * pay1;
      p6 <= pax1 * bay1;
      tex2 <= tex1;
    end
  end

  // stage 3: denominator and two numerators
  logic signed [CROSS_W-1:0] d3, vn3, wn3;
  tex_pts_t                  tex3;
  item_ctl_t                 ctl3;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3 <= '0;
    end else if (advance) begin
      ctl3 <= ctl2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      d3   <= {p1[PROD_W-1], p1} - {p2[PROD_W-1], p2};
      vn3  <= {p3[PROD_W-1], p3} - {p4[PROD_W-1], p4};
      wn3  <= {p5[PROD_W-1], p5} - {p6[PROD_W-1], p6};
      tex3 <= tex2;
    end
  end

  // stage 4: sign fold and inside test
  logic signed [SUM_W-1:0] sd, sv, sw, su;
  logic                    in_tri;
  logic [WT_W-1:0]         ud4, u4, v4, w4;
  tex_pts_t                tex4;
  item_ctl_t               ctl4, ctl4_next;

  always_comb begin
    sd = {{2{d3[CROSS_W-1]}}, d3};
    sv = {{2{vn3[CROSS_W-1]}}, vn3};
    sw = {{2{wn3[CROSS_W-1]}}, wn3};
    su = sd - sv - sw;
    if (sd < 0) begin
      sd = -sd;
      sv = -sv;
      sw = -sw;
      su = -su;
    end
    in_tri = (sd != 0) && (su > 0) && (su < sd) && (sv > 0) && (sv < sd)
             && (sw > 0) && (sw < sd);
    ctl4_next     = ctl3;
    ctl4_next.hit = ctl3.load ? ctl3.hit : (ctl3.hit && in_tri);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl4 <= '0;
    end else if (advance) begin
      ctl4 <= ctl4_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ud4  <= sd[WT_W-1:0];
      u4   <= su[WT_W-1:0];
      v4   <= sv[WT_W-1:0];
      w4   <= sw[WT_W-1:0];
      tex4 <= tex3;
    end
  end

  // stage 5: weight by texture point
  logic [NUM_W-1:0] mux5, mvx5, mwx5, muy5, mvy5, mwy5;
  logic [WT_W-1:0]  ud5;
  item_ctl_t        ctl5;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl5 <= '0;
    end else if (advance) begin
      ctl5 <= ctl4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mux5 <= u4 * tex4.ax;
      mvx5 <= v4 * tex4.bx;
      mwx5 <= w4 * ctx;
      muy5 <= u4 * tex4.ay;
      mvy5 <= v4 * tex4.by;
      mwy5 <= w4 * cty;
      ud5  <= ud4;
    end
  end

  // stage 6: numerators
  logic [NUM_W-1:0] nx6, ny6;
  logic [WT_W-1:0]  ud6;
  item_ctl_t        ctl6;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl6 <= '0;
    end else if (advance) begin
      ctl6 <= ctl5;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      nx6 <= mux5 + mvx5 + mwx5;
      ny6 <= muy5 + mvy5 + mwy5;
      ud6 <= ud5;
    end
  end

  // divider: one quotient bit per stage, x and y side by side
  div_t            dvx [QUOT_W];
  div_t            dvy [QUOT_W];
  logic [WT_W-1:0] dvd [QUOT_W];
  item_ctl_t       dvc [QUOT_W];
  div_t            x_init, y_init;

  assign x_init.rem = nx6[NUM_W-1:TEXC_W];
  assign x_init.quo = {nx6[TEXC_W-1:0], {FRAC_W{1'b0}}};
  assign y_init.rem = ny6[NUM_W-1:TEXC_W];
  assign y_init.quo = {ny6[TEXC_W-1:0], {FRAC_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      dvc[0] <= '0;
    end else if (advance) begin
      dvc[0] <= ctl6;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dvx[0] <= div_step(x_init, ud6);
      dvy[0] <= div_step(y_init, ud6);
      dvd[0] <= ud6;
    end
  end

  for (genvar k = 1; k < QUOT_W; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dvc[k] <= '0;
      end else if (advance) begin
        dvc[k] <= dvc[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        dvx[k] <= div_step(dvx[k-1], dvd[k-1]);
        dvy[k] <= div_step(dvy[k-1], dvd[k-1]);
        dvd[k] <= dvd[k-1];
      end
    end
  end

  // fetch: four parity banks, write for loads, read the 2x2 quad
  item_ctl_t         fc;
  logic [TEXC_W-1:0] x0, y0;
  logic [TEXC_W:0]   x1, y1;
  logic [FRAC_W-1:0] fx, fy;
  logic [TEXC_W:0]   xb [4];
  logic [TEXC_W:0]   yb [4];
  logic [20:0]       afull [4];
  logic [ADDR_W-1:0] raddr [4];
  logic [3:0]        bmask;
  logic [1:0]        ld_bank;

  assign fc      = dvc[QUOT_W-1];
  assign x0      = dvx[QUOT_W-1].quo[QUOT_W-1:FRAC_W];
  assign y0      = dvy[QUOT_W-1].quo[QUOT_W-1:FRAC_W];
  assign fx      = dvx[QUOT_W-1].quo[FRAC_W-1:0];
  assign fy      = dvy[QUOT_W-1].quo[FRAC_W-1:0];
  assign x1      = {1'b0, x0} + 11'd1;
  assign y1      = {1'b0, y0} + 11'd1;
  assign ld_bank = {fc.ly[0], fc.lx[0]};

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      if (fc.load) begin
        xb[b] = {1'b0, fc.lx};
        yb[b] = {1'b0, fc.ly};
      end else begin
        xb[b] = (x0[0] == b[0]) ? {1'b0, x0} : x1;
        yb[b] = (y0[0] == b[1]) ? {1'b0, y0} : y1;
      end
      bmask[b] = (xb[b] < TW11) && (yb[b] < TH11);
      afull[b] = (tsel ? 21'(BANK_TEX) : 21'd0)
                 + 21'(yb[b][TEXC_W:1]) * 21'(BANK_W) + 21'(xb[b][TEXC_W:1]);
      raddr[b] = afull[b][ADDR_W-1:0];
    end
  end

  logic [RGB_W-1:0]  rd [4];
  logic [3:0]        mask_r;
  logic              px0_r, py0_r;
  logic [FRAC_W-1:0] fx_r, fy_r;
  item_ctl_t         ctl_r;
  logic [3:0]        bank_we;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [RGB_W-1:0] mem [BANK_DEPTH];

    assign bank_we[b] = advance && fc.vld && fc.load && fc.hit && (ld_bank == 2'(b));

    always_ff @(posedge clk) begin
      if (bank_we[b]) begin
        mem[raddr[b]] <= fc.rgb;
      end
      if (advance) begin
        rd[b] <= mem[raddr[b]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_r <= '0;
    end else if (advance) begin
      ctl_r <= fc;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mask_r <= bmask;
      px0_r  <= x0[0];
      py0_r  <= y0[0];
      fx_r   <= fx;
      fy_r   <= fy;
    end
  end

  // blend, horizontal pass
  logic [RGB_W-1:0] c00, c10, c01, c11;
  logic [8:0]       wx, fx9;
  logic [16:0]      top_next [3];
  logic [16:0]      bot_next [3];
  logic [16:0]      top_b [3];
  logic [16:0]      bot_b [3];
  logic [FRAC_W-1:0] fy_b;
  item_ctl_t        ctl_b;

  always_comb begin
    c00 = rd[{py0_r, px0_r}] & {RGB_W{mask_r[{py0_r, px0_r}]}};
    c10 = rd[{py0_r, !px0_r}] & {RGB_W{mask_r[{py0_r, !px0_r}]}};
    c01 = rd[{!py0_r, px0_r}] & {RGB_W{mask_r[{!py0_r, px0_r}]}};
    c11 = rd[{!py0_r, !px0_r}] & {RGB_W{mask_r[{!py0_r, !px0_r}]}};
    fx9 = {1'b0, fx_r};
    wx  = 9'd256 - fx9;
    for (int c = 0; c < 3; c++) begin
      top_next[c] = wx * c00[8*c +: 8] + fx9 * c10[8*c +: 8];
      bot_next[c] = wx * c01[8*c +: 8] + fx9 * c11[8*c +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_b <= '0;
    end else if (advance) begin
      ctl_b <= ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      top_b <= top_next;
      bot_b <= bot_next;
      fy_b  <= fy_r;
    end
  end

  // blend, vertical pass into the output register
  logic [8:0]  wy, fy9;
  logic [25:0] mix [3];
  logic        cov;
  logic [23:0] rgb_next;

  always_comb begin
    fy9 = {1'b0, fy_b};
    wy  = 9'd256 - fy9;
    cov = ctl_b.vld && !ctl_b.load && ctl_b.hit;
    for (int c = 0; c < 3; c++) begin
      mix[c] = wy * top_b[c] + fy9 * bot_b[c];
    end
    // tdata is red low, blue high; texel is red high
    rgb_next = cov ? {mix[0][23:16], mix[1][23:16], mix[2][23:16]} : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= ctl_b.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= rgb_next;
      m_axis_tuser <= cov;
    end
  end

  `ASSERT_CLK(a_skid_holds, skid_full && !advance |=> skid_full, "skid dropped an item")
  `ASSERT_CLK(a_skid_src, $rose(skid_full) |-> $past(s_axis_tvalid), "skid filled without input")
  `ASSERT_ALWAYS(a_we_adv, (bank_we == 4'd0) || advance, "texel write while stalled")
  `ASSERT_ALWAYS(a_we_one, $onehot0(bank_we), "more than one bank written")
  `ASSERT_ALWAYS(a_uncov_black, !m_axis_tvalid || m_axis_tuser || (m_axis_tdata == '0),
                 "uncovered pixel has color")

endmodule
